// ===== design/oahm_pkg.sv =====
package oahm_pkg;

    // Field widths of the words on the ports.
    localparam int ACTION_W = 3;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int SEL_W    = 8;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;
    localparam int LIVE_W   = 9;
    localparam int LIMIT_W  = 9;
    localparam int FLAG_W   = 2;

    // Load limit after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd197;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_LOOKUP    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_SLOT = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

    // Slot flag codes as held in the flag memory.
    typedef enum logic [FLAG_W-1:0] {
        FLAG_LIVE  = 2'd0,
        FLAG_TOMB  = 2'd1,
        FLAG_EMPTY = 2'd2
    } t_flag;

    // How an action finishes.
    typedef enum logic [3:0] {
        FIN_NONE,
        FIN_FOUND,
        FIN_ABSENT,
        FIN_INSERT,
        FIN_FULL,
        FIN_REMOVE,
        FIN_CLEAR,
        FIN_READSLOT,
        FIN_OTHER
    } t_fin;

    // Controller states.
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } t_state;

    // Input word.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic                value_given;
        logic [SEL_W-1:0]    slot_select;
    } t_in;

    // Result word.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [KEY_W-1:0]    key_out;
        logic [VALUE_W-1:0]  value_out;
        logic                populated;
        logic [LIVE_W-1:0]   live_count;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd;
        logic adv;
        logic eval;
        logic sweep;
        logic fin_en;
        t_fin fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACTION_W-1:0] in_action;
        logic                flag_empty;
        logic                flag_tomb;
        logic                key_hit;
        logic                have_tomb;
        logic                wrap;
        logic                limit_hit;
        logic                sweep_last;
        logic                out_free;
    } t_sts;

endpackage

// ===== design/oahm_ram.sv =====
module oahm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/oahm_ctrl.sv =====
module oahm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  oahm_pkg::t_sts i_sts,
    output oahm_pkg::t_cmd o_cmd
);

    import oahm_pkg::*;

    t_state r_state, n_state;
    t_fin   r_fin, n_fin;

    // State register; reset starts with the sweep that empties every slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_fin   <= FIN_NONE;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        n_fin        = r_fin;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.rd     = 1'b0;
        o_cmd.adv    = 1'b0;
        o_cmd.eval   = 1'b0;
        o_cmd.sweep  = 1'b0;
        o_cmd.fin_en = 1'b0;
        o_cmd.fin    = r_fin;
        case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = (r_fin == FIN_CLEAR) ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_sts.in_action)
                        ACT_LOOKUP: begin
                            n_fin   = FIN_FOUND;
                            n_state = ST_READ;
                        end
                        ACT_INSERT: begin
                            n_fin   = FIN_INSERT;
                            n_state = ST_READ;
                        end
                        ACT_REMOVE: begin
                            n_fin   = FIN_REMOVE;
                            n_state = ST_READ;
                        end
                        ACT_READ_SLOT: begin
                            n_fin   = FIN_READSLOT;
                            n_state = ST_READ;
                        end
                        ACT_CLEAR: begin
                            n_fin   = FIN_CLEAR;
                            n_state = ST_SWEEP;
                        end
                        default: begin
                            n_fin   = FIN_OTHER;
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (r_fin == FIN_READSLOT) begin
                    n_state = ST_FINISH;
                end else if (i_sts.flag_empty || i_sts.key_hit) begin
                    // The probe ends on an empty slot or on the key itself.
                    n_state = ST_FINISH;
                    if (r_fin == FIN_INSERT) begin
                        if (i_sts.flag_empty && !i_sts.have_tomb && i_sts.limit_hit) begin
                            n_fin = FIN_FULL;
                        end
                    end else if (!i_sts.key_hit) begin
                        n_fin = FIN_ABSENT;
                    end
                end else begin
                    // Step on; back at the home slot the search gives up.
                    o_cmd.adv = 1'b1;
                    if (i_sts.wrap) begin
                        n_state = ST_FINISH;
                        if (r_fin == FIN_INSERT) begin
                            n_fin = (i_sts.have_tomb || i_sts.flag_tomb) ? FIN_INSERT
                                                                         : FIN_FULL;
                        end else begin
                            n_fin = FIN_ABSENT;
                        end
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_en = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/oahm_dpath.sv =====
module oahm_dpath #(
    parameter int CAPACITY    = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  oahm_pkg::t_in                   i_in,
    input  logic                            i_cfg_valid,
    input  logic [oahm_pkg::LIMIT_W-1:0]    i_cfg_data,
    input  oahm_pkg::t_cmd                  i_cmd,
    output oahm_pkg::t_sts                  o_sts,
    output oahm_pkg::t_out                  o_out,
    output logic                            o_out_valid,
    input  logic                            i_out_ready
);

    import oahm_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_given;
    logic [IDX_W-1:0]       r_home;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_step;
    logic [IDX_W-1:0]       r_tomb;
    logic                   r_have_tomb;
    logic [IDX_W-1:0]       r_place;
    t_flag                  r_place_kind;
    logic [CNT_W-1:0]       r_entry, n_entry;
    logic [CNT_W-1:0]       r_used, n_used;
    logic [LIMIT_W-1:0]     r_limit;
    logic [IDX_W-1:0]       r_clr_idx;
    t_out                   r_out, n_out;
    logic                   r_out_valid;

    logic [KEY_WIDTH-1:0]   w_in_key;
    logic [FLAG_W-1:0]      w_rd_flag;
    logic [KEY_WIDTH-1:0]   w_rd_key;
    logic [VALUE_WIDTH-1:0] w_rd_val;
    logic                   w_empty, w_tomb, w_live, w_hit;
    logic [IDX_W-1:0]       w_step_n, w_idx_n;
    logic                   w_fl_we;
    logic [IDX_W-1:0]       w_fl_addr;
    logic [FLAG_W-1:0]      w_fl_data;
    logic                   w_ins, w_key_we, w_val_we;

    // Memories for slot flags, keys and values, all read at the probe index.
    oahm_ram #(.WIDTH(FLAG_W), .DEPTH(CAPACITY)) u_flag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_fl_we),
        .i_wr_addr (w_fl_addr),
        .i_wr_data (w_fl_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_flag)
    );

    oahm_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_key_we),
        .i_wr_addr (r_place),
        .i_wr_data (r_key),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_key)
    );

    oahm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_val_we),
        .i_wr_addr (r_place),
        .i_wr_data (r_value),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_val)
    );

    // Decode of the slot just read and the next triangular probe index.
    assign w_in_key = KEY_WIDTH'(i_in.key);
    assign w_empty  = (w_rd_flag == FLAG_EMPTY);
    assign w_tomb   = (w_rd_flag == FLAG_TOMB);
    assign w_live   = (w_rd_flag == FLAG_LIVE);
    assign w_hit    = w_live && (w_rd_key == r_key);
    assign w_step_n = r_step + IDX_W'(1);
    assign w_idx_n  = r_idx + w_step_n;

    // Status to the controller.
    always_comb begin
        o_sts.in_action  = i_in.action;
        o_sts.flag_empty = w_empty;
        o_sts.flag_tomb  = w_tomb;
        o_sts.key_hit    = w_hit;
        o_sts.have_tomb  = r_have_tomb;
        o_sts.wrap       = (w_idx_n == r_home);
        o_sts.limit_hit  = (CMP_W'(r_used) >= CMP_W'(r_limit));
        o_sts.sweep_last = (r_clr_idx == IDX_W'(CAPACITY - 1));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // Memory writes: the clearing sweep, insert and remove.
    assign w_ins    = i_cmd.fin_en && (i_cmd.fin == FIN_INSERT);
    assign w_key_we = w_ins;
    assign w_val_we = w_ins && r_given;

    always_comb begin
        w_fl_we   = 1'b0;
        w_fl_addr = r_place;
        w_fl_data = FLAG_LIVE;
        if (i_cmd.sweep) begin
            w_fl_we   = 1'b1;
            w_fl_addr = r_clr_idx;
            w_fl_data = FLAG_EMPTY;
        end else if (w_ins) begin
            w_fl_we = 1'b1;
        end else if (i_cmd.fin_en && (i_cmd.fin == FIN_REMOVE)) begin
            w_fl_we   = 1'b1;
            w_fl_data = FLAG_TOMB;
        end
    end

    // Counts and the result word for the finishing action.
    always_comb begin
        n_entry = r_entry;
        n_used  = r_used;
        case (i_cmd.fin)
            FIN_INSERT: begin
                if (r_place_kind == FLAG_EMPTY) begin
                    n_entry = r_entry + CNT_W'(1);
                    n_used  = r_used + CNT_W'(1);
                end else if (r_place_kind == FLAG_TOMB) begin
                    n_entry = r_entry + CNT_W'(1);
                end
            end
            FIN_REMOVE: n_entry = r_entry - CNT_W'(1);
            FIN_CLEAR: begin
                n_entry = '0;
                n_used  = '0;
            end
            default: ;
        endcase

        n_out.status     = STAT_OK;
        n_out.slot_index = '0;
        n_out.key_out    = '0;
        n_out.value_out  = '0;
        n_out.populated  = 1'b0;
        n_out.live_count = LIVE_W'(n_entry);
        case (i_cmd.fin)
            FIN_FOUND: begin
                n_out.slot_index = SLOT_W'(r_place);
                n_out.value_out  = VALUE_W'(w_rd_val);
            end
            FIN_ABSENT: n_out.status = STAT_ABSENT;
            FIN_FULL:   n_out.status = STAT_FULL;
            FIN_INSERT, FIN_REMOVE: n_out.slot_index = SLOT_W'(r_place);
            FIN_READSLOT: begin
                n_out.slot_index = SLOT_W'(r_idx);
                if (w_live) begin
                    n_out.populated = 1'b1;
                    n_out.key_out   = KEY_W'(w_rd_key);
                    n_out.value_out = VALUE_W'(w_rd_val);
                end
            end
            default: ;
        endcase
    end

    // Control registers: counts, load limit, sweep index and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry     <= '0;
            r_used      <= '0;
            r_limit     <= LIMIT_RESET;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.sweep) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (i_cmd.fin_en) begin
                r_entry     <= n_entry;
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and probe registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key       <= w_in_key;
            r_value     <= VALUE_WIDTH'(i_in.value);
            r_given     <= i_in.value_given;
            r_home      <= IDX_W'(w_in_key);
            r_idx       <= (i_in.action == ACT_READ_SLOT) ? IDX_W'(i_in.slot_select)
                                                         : IDX_W'(w_in_key);
            r_step      <= '0;
            r_have_tomb <= 1'b0;
        end else if (i_cmd.adv) begin
            r_step <= w_step_n;
            r_idx  <= w_idx_n;
            if (w_tomb) begin
                r_tomb      <= r_idx;
                r_have_tomb <= 1'b1;
            end
        end
        // The slot an insert would take, or the slot found.
        if (i_cmd.eval) begin
            if (w_empty || w_hit) begin
                r_place      <= (w_empty && r_have_tomb) ? r_tomb : r_idx;
                r_place_kind <= w_empty ? (r_have_tomb ? FLAG_TOMB : FLAG_EMPTY)
                                        : FLAG_LIVE;
            end else begin
                r_place      <= w_tomb ? r_idx : r_tomb;
                r_place_kind <= FLAG_TOMB;
            end
        end
        if (i_cmd.fin_en) begin
            r_out <= n_out;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/open_addressing_hash_map_unit.sv =====
// Key/value table with open addressing, identity hash and triangular probing.
// Input channel (i_in_valid / o_in_ready) takes one action word: lookup,
// insert or update, remove, clear or read slot. Output channel
// (o_out_valid / i_out_ready) returns exactly one result word per action.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the load
// limit; it is always ready and is meant to be written while the unit idles.
// Each probe is one memory read and one compare, since the
// flag, key and value memories each have a single registered read port.
// A new action word is accepted only after the previous action has finished;
// clear sweeps the flag memory one slot per cycle.
// After reset the same sweep runs over every slot with o_in_ready low.
// The result sits in an output register; a new word is accepted while it
// waits, but that word completes only once the receiver has taken the result.
module open_addressing_hash_map_unit #(
    parameter int CAPACITY    = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  oahm_pkg::t_in                i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output oahm_pkg::t_out               o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [oahm_pkg::LIMIT_W-1:0] i_cfg_data
);

    import oahm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer for the probe walk, the sweep and the result handshake.
    oahm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Memories, counters and the result register.
    oahm_dpath #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    assign o_cfg_ready = 1'b1;

endmodule

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import oahm_pkg::*;

    localparam int SLOTS         = 256;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    // Codes that the block treats as no operation.
    localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_MID   = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

    // Shadow copy of the table: predicts the result word of every accepted action
    // word and compares it with what comes out of the block.
    class hash_map_tracker;
        t_flag              flags[SLOTS];
        logic [KEY_W-1:0]   keys[SLOTS];
        logic [VALUE_W-1:0] vals[SLOTS];
        bit                 written[SLOTS];
        int unsigned        live;
        int unsigned        used;
        logic [LIMIT_W-1:0] limit;
        t_out               due_results[$];
        int unsigned        mismatches;

        function new();
            foreach (flags[i]) begin
                flags[i]   = FLAG_EMPTY;
                keys[i]    = '0;
                vals[i]    = '0;
                written[i] = 1'b0;
            end
            live       = 0;
            used       = 0;
            limit      = LIMIT_RESET;
            mismatches = 0;
        endfunction

        // Triangular walk from the home slot; true when the key sits in a live slot.
        function bit probe_find(input logic [KEY_W-1:0] k, output logic [SLOT_W-1:0] at);
            logic [SLOT_W-1:0] i;
            logic [SLOT_W-1:0] home;
            int unsigned       step;
            i    = k[SLOT_W-1:0];
            home = i;
            step = 0;
            while (flags[i] != FLAG_EMPTY && (flags[i] == FLAG_TOMB || keys[i] != k)) begin
                step++;
                i = i + step[SLOT_W-1:0];
                if (i == home)
                    return 1'b0;
            end
            at = i;
            return flags[i] == FLAG_LIVE;
        endfunction

        // Slot an insert would use: the key's own slot, else the last tombstone
        // passed, else the empty slot that ended the walk.
        function bit probe_place(input logic [KEY_W-1:0] k, output logic [SLOT_W-1:0] at);
            logic [SLOT_W-1:0] i;
            logic [SLOT_W-1:0] home;
            logic [SLOT_W-1:0] tomb;
            bit                have_tomb;
            int unsigned       step;
            i         = k[SLOT_W-1:0];
            home      = i;
            tomb      = '0;
            have_tomb = 1'b0;
            step      = 0;
            while (flags[i] != FLAG_EMPTY && (flags[i] == FLAG_TOMB || keys[i] != k)) begin
                if (flags[i] == FLAG_TOMB) begin
                    tomb      = i;
                    have_tomb = 1'b1;
                end
                step++;
                i = i + step[SLOT_W-1:0];
                if (i == home) begin
                    at = tomb;
                    return have_tomb;
                end
            end
            at = (flags[i] == FLAG_EMPTY && have_tomb) ? tomb : i;
            return 1'b1;
        endfunction

        // An insert without a value must not land on a slot whose value was never set.
        function bit value_undefined(input logic [KEY_W-1:0] k);
            logic [SLOT_W-1:0] s;
            return probe_place(k, s) && !written[s];
        endfunction

        // Any live key, found from a random starting slot.
        function bit pick_live_key(output logic [KEY_W-1:0] k);
            int unsigned start;
            int unsigned idx;
            start = $urandom_range(0, SLOTS - 1);
            for (int j = 0; j < SLOTS; j++) begin
                idx = (start + j) % SLOTS;
                if (flags[idx] == FLAG_LIVE) begin
                    k = keys[idx];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Applies one accepted action word and queues the result word it must give.
        function void note_action(input t_in w);
            t_out              e;
            logic [SLOT_W-1:0] s;
            e = '0;
            case (w.action)
                ACT_LOOKUP: begin
                    if (probe_find(w.key, s)) begin
                        e.slot_index = s;
                        e.value_out  = vals[s];
                    end else begin
                        e.status = STAT_ABSENT;
                    end
                end
                ACT_INSERT: begin
                    if (!probe_place(w.key, s) || (flags[s] == FLAG_EMPTY && used >= limit)) begin
                        e.status = STAT_FULL;
                    end else begin
                        keys[s] = w.key;
                        if (w.value_given) begin
                            vals[s]    = w.value;
                            written[s] = 1'b1;
                        end
                        if (flags[s] == FLAG_EMPTY) begin
                            live++;
                            used++;
                        end else if (flags[s] == FLAG_TOMB) begin
                            live++;
                        end
                        flags[s]     = FLAG_LIVE;
                        e.slot_index = s;
                    end
                end
                ACT_REMOVE: begin
                    if (probe_find(w.key, s)) begin
                        flags[s] = FLAG_TOMB;
                        live--;
                        e.slot_index = s;
                    end else begin
                        e.status = STAT_ABSENT;
                    end
                end
                ACT_CLEAR: begin
                    // The key and value stores keep their contents.
                    foreach (flags[i])
                        flags[i] = FLAG_EMPTY;
                    live = 0;
                    used = 0;
                end
                ACT_READ_SLOT: begin
                    e.slot_index = w.slot_select;
                    if (flags[w.slot_select] == FLAG_LIVE) begin
                        e.populated = 1'b1;
                        e.key_out   = keys[w.slot_select];
                        e.value_out = vals[w.slot_select];
                    end
                end
                default: ;
            endcase
            e.live_count = LIVE_W'(live);
            due_results.push_back(e);
        endfunction

        function void compare_field(input string name, input logic [63:0] exp,
                                    input logic [63:0] act);
            if (exp !== act) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
                mismatches++;
            end
        endfunction

        // Compares a delivered result word with the oldest one still due.
        function void check_result(input t_out r);
            t_out e;
            if (due_results.size() == 0) begin
                $error("result word arrived with no action outstanding");
                mismatches++;
                return;
            end
            e = due_results.pop_front();
            compare_field("status", e.status, r.status);
            compare_field("slot_index", e.slot_index, r.slot_index);
            compare_field("key_out", e.key_out, r.key_out);
            compare_field("value_out", e.value_out, r.value_out);
            compare_field("populated", e.populated, r.populated);
            compare_field("live_count", e.live_count, r.live_count);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in                i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out               o_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [LIMIT_W-1:0] i_cfg_data;

    hash_map_tracker sb;
    int              idle_cycles   = 0;
    int              send_idle_pct = 11;
    int              recv_idle_pct = 81;
    int              hold_request  = 0;

    open_addressing_hash_map_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, or a long hold when one is requested.
    initial begin
        int hold;
        hold        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold         = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Sample the handshakes; results are checked before the same edge's action is noted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out);
            if (i_in_valid && o_in_ready)
                sb.note_action(i_in);
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Nothing has moved for far longer than the slowest action could take.
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic t_in make_word(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k,
                                      input logic [VALUE_W-1:0] v, input logic given,
                                      input logic [SEL_W-1:0] sel);
        t_in w;
        w.action      = act;
        w.key         = k;
        w.value       = v;
        w.value_given = given;
        w.slot_select = sel;
        return w;
    endfunction

    // Random action word. Keys hit live entries or crowd home slots 0 to 31, so that
    // probe chains grow long (mostly so outside fill mode); in fill mode the insert-heavy mix fills the table.
    function automatic t_in random_word(input bit fill);
        t_in              w;
        int unsigned      pick;
        int unsigned      src;
        bit               have_key;
        logic [KEY_W-1:0] k;
        w.value       = $urandom;
        w.value_given = 1'($urandom_range(0, 1));
        w.slot_select = SEL_W'($urandom_range(0, SLOTS - 1));
        pick          = $urandom_range(0, 99);
        if (fill)
            w.action = pick < 80 ? ACT_INSERT : pick < 88 ? ACT_LOOKUP :
                       pick < 93 ? ACT_REMOVE : pick < 98 ? ACT_READ_SLOT :
                       ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        else
            w.action = pick < 30 ? ACT_LOOKUP : pick < 62 ? ACT_INSERT :
                       pick < 80 ? ACT_REMOVE : pick < 93 ? ACT_READ_SLOT :
                       pick < 95 ? ACT_CLEAR :
                       ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        src      = $urandom_range(0, 99);
        have_key = sb.pick_live_key(k);
        if (src < (fill ? 15 : 40) && have_key)
            w.key = k;
        else if (src < (fill ? 40 : 80))
            w.key = {24'($urandom_range(0, 15)), 8'($urandom_range(0, 31))};
        else
            w.key = $urandom;
        return w;
    endfunction

    // Offers one action word and returns on the falling edge after it is taken.
    task automatic send_word(input t_in w);
        if (w.action == ACT_INSERT && !w.value_given && sb.value_undefined(w.key))
            w.value_given = 1'b1;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering words until every outstanding result has been delivered.
    task automatic drain();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (sb.due_results.size() != 0);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.limit = lim;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hand-picked words: collisions on home slot zero, update in place, tombstone
    // reuse, no-op codes, the top slot and stale values surviving a clear.
    task automatic run_directed();
        send_word(make_word(ACT_LOOKUP, 32'h0000_0000, 32'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, 8'h00));
        send_word(make_word(ACT_INSERT, 32'h0000_0100, 32'hFFFF_FFFF, 1'b1, 8'h00));
        send_word(make_word(ACT_INSERT, 32'h0000_0200, 32'h5A5A_5A5A, 1'b1, 8'h00));
        send_word(make_word(ACT_LOOKUP, 32'h0000_0100, 32'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_INSERT, 32'h0000_0100, 32'h1111_2222, 1'b0, 8'h00));
        send_word(make_word(ACT_INSERT, 32'h0000_0100, 32'h1234_5678, 1'b1, 8'h00));
        send_word(make_word(ACT_REMOVE, 32'h0000_0100, 32'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_LOOKUP, 32'h0000_0200, 32'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_REMOVE, 32'h0000_0100, 32'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_INSERT, 32'h0000_0300, 32'hA5A5_A5A5, 1'b1, 8'h00));
        send_word(make_word(ACT_READ_SLOT, 32'h0, 32'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_READ_SLOT, 32'h0, 32'h0, 1'b0, 8'h01));
        send_word(make_word(ACT_READ_SLOT, 32'h0, 32'h0, 1'b0, 8'h02));
        send_word(make_word(ACT_UNUSED_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF));
        send_word(make_word(ACT_UNUSED_MID, 32'h0000_0200, 32'h0, 1'b0, 8'h01));
        send_word(make_word(ACT_UNUSED_LAST, 32'h0000_0100, 32'h0, 1'b1, 8'h03));
        send_word(make_word(ACT_INSERT, 32'hFFFF_FFFF, 32'h8000_0001, 1'b1, 8'h00));
        send_word(make_word(ACT_READ_SLOT, 32'h0, 32'h0, 1'b0, 8'hFF));
        send_word(make_word(ACT_CLEAR, 32'h0, 32'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_LOOKUP, 32'h0000_0200, 32'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_INSERT, 32'h0000_0200, 32'hDEAD_BEEF, 1'b0, 8'h00));
        send_word(make_word(ACT_LOOKUP, 32'h0000_0200, 32'h0, 1'b0, 8'h00));
        send_word(make_word(ACT_READ_SLOT, 32'h0, 32'h0, 1'b0, 8'h00));
    endtask

    // One random phase under a fresh load limit, written while the block is idle.
    task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int count, input bit fill,
                             input int s_idle, input int r_idle, input bit clear_first,
                             input bit pressure);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_limit(lim);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        if (clear_first)
            send_word(make_word(ACT_CLEAR, $urandom, $urandom, 1'b0, 8'h00));
        for (int n = 0; n < count; n++) begin
            // Hold the result side while words keep coming, then let the block run dry.
            if (pressure && n == 150)
                hold_request = HOLD_CYCLES;
            if (pressure && n == 450)
                drain();
            send_word(random_word(fill));
        end
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_phase(9'd1, 120, 1'b0, 11, 81, 1'b1, 1'b0);
        run_phase(9'd0, 60, 1'b0, 11, 81, 1'b0, 1'b0);
        run_phase(9'd256, 420, 1'b1, 81, 11, 1'b1, 1'b0);
        run_phase(LIMIT_W'($urandom_range(2, 255)), 300, 1'b0, 81, 11, 1'b1, 1'b0);
        run_phase(9'd511, 80, 1'b0, 81, 11, 1'b0, 1'b0);
        run_phase(LIMIT_RESET, 800, 1'b0, 0, 0, 1'b1, 1'b1);

        drain();
        repeat (20) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.due_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== open_addressing_hash_map_unit.f =====
design/oahm_pkg.sv
design/oahm_ram.sv
design/oahm_ctrl.sv
design/oahm_dpath.sv
design/open_addressing_hash_map_unit.sv
dv/testbench.sv
